@@ design/spq_pkg.sv @@
// Shared types and codes for the sorted priority queue.
package spq_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned PRIO_W   = 16;
    localparam int unsigned OCC_W    = 5;
    localparam int unsigned STATUS_W = 2;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  prio;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t ent;
    } slot_t;

    typedef struct packed {
        logic   ins;
        logic   rem;
        entry_t ent;
    } cmd_t;

endpackage

@@ design/sorted_priority_queue.sv @@
// Top level of the sorted priority queue built as a chain of slot cells.
//
// Input channel s_axis_*: one item per operation. tuser carries the operation
// (insert or remove), tdata the value and priority of an insert.
// Result channel m_axis_*: exactly one item per input item, in order, with
// status, the removed entry (zero unless a remove succeeded) and occupancy.
// The queue is a row of CAPACITY cells kept sorted by priority; equal
// priorities leave first-in, first-out. Every cell compares its own priority
// with the incoming one and either holds, takes the new entry or takes its
// left neighbor's entry; a remove shifts the whole row left by one.
// Each accepted item's result is registered in the output register.
// Throughput is one item per cycle unless the receiver stalls, since all cells update as the item is accepted.
// When the receiver stalls, the output register holds and s_axis_tready drops
// until the result is taken; a new item is accepted in the cycle it leaves.
// Reset empties the queue and clears the output register's valid flag.
// An insert into a full queue is dropped with overflow status; a remove from
// an empty queue reports underflow and leaves the queue unchanged.
module sorted_priority_queue #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // item_value[31:0], item_priority[47:32]
    input  logic [0:0]  s_axis_tuser,   // op[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // status[1:0], removed_valid[2],
                                        // removed_value[34:3],
                                        // removed_priority[50:35], occupancy[55:51]
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    logic               accept;
    spq_pkg::op_t       op;
    spq_pkg::cmd_t      cmd;
    logic               full, empty;
    logic [CNT_W-1:0]   count_reg, count_next;

    spq_pkg::slot_t     slots [CAPACITY];
    logic               keeps [CAPACITY];

    logic               out_valid_reg;
    spq_pkg::status_t   status_reg, status_next;
    logic               rvalid_reg, rvalid_next;
    spq_pkg::entry_t    rent_reg, rent_next;
    logic [spq_pkg::OCC_W-1:0] occ_reg;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign op            = spq_pkg::op_t'(s_axis_tuser[0]);
    assign full          = (count_reg == CNT_W'(CAPACITY));
    assign empty         = (count_reg == '0);

    assign cmd.ins       = accept && (op == spq_pkg::OP_INSERT) && !full;
    assign cmd.rem       = accept && (op == spq_pkg::OP_REMOVE) && !empty;
    assign cmd.ent.value = s_axis_tdata[31:0];
    assign cmd.ent.prio  = s_axis_tdata[47:32];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            spq_pkg::slot_t left_s, right_s;
            logic           left_k;
            if (gi == 0) begin : g_head
                assign left_s = '0;
                assign left_k = 1'b1;
            end else begin : g_body
                assign left_s = slots[gi-1];
                assign left_k = keeps[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_tail
                assign right_s = '0;
            end else begin : g_mid
                assign right_s = slots[gi+1];
            end
            spq_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .cmd        (cmd),
                .left_slot  (left_s),
                .left_keep  (left_k),
                .right_slot (right_s),
                .slot       (slots[gi]),
                .keep       (keeps[gi])
            );
        end
    endgenerate

    always_comb begin
        count_next  = count_reg;
        status_next = spq_pkg::ST_OK;
        rvalid_next = 1'b0;
        rent_next   = '0;
        if (op == spq_pkg::OP_INSERT) begin
            if (full) begin
                status_next = spq_pkg::ST_OVERFLOW;
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
        end else begin
            if (empty) begin
                status_next = spq_pkg::ST_UNDERFLOW;
            end else begin
                count_next  = count_reg - CNT_W'(1);
                rvalid_next = 1'b1;
                rent_next   = slots[0].ent;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            status_reg <= status_next;
            rvalid_reg <= rvalid_next;
            rent_reg   <= rent_next;
            occ_reg    <= spq_pkg::OCC_W'(count_next);
        end
    end

    assign m_axis_tvalid       = out_valid_reg;
    assign m_axis_tdata[1:0]   = status_reg;
    assign m_axis_tdata[2]     = rvalid_reg;
    assign m_axis_tdata[34:3]  = rent_reg.value;
    assign m_axis_tdata[50:35] = rent_reg.prio;
    assign m_axis_tdata[55:51] = occ_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_head_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        slots[0].valid == !empty)
        else $error("head cell valid disagrees with count");

    a_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (op == spq_pkg::OP_REMOVE) && empty |=>
        m_axis_tvalid && (m_axis_tdata[1:0] == spq_pkg::ST_UNDERFLOW) && !m_axis_tdata[2])
        else $error("remove from empty queue not flagged");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the queue");

endmodule

@@ design/spq_cell.sv @@
// One slot of the sorted chain: holds an entry and trades with its neighbors.
module spq_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  spq_pkg::cmd_t  cmd,
    input  spq_pkg::slot_t left_slot,
    input  logic           left_keep,
    input  spq_pkg::slot_t right_slot,
    output spq_pkg::slot_t slot,
    output logic           keep
);

    logic                 valid_reg, valid_next;
    spq_pkg::entry_t      ent_reg, ent_next;

    // entries at or ahead of the new priority stay put on insert
    assign keep = valid_reg && ($signed(ent_reg.prio) <= $signed(cmd.ent.prio));

    always_comb begin
        valid_next = valid_reg;
        ent_next   = ent_reg;
        if (cmd.ins && !keep) begin
            if (left_keep) begin
                valid_next = 1'b1;
                ent_next   = cmd.ent;
            end else begin
                valid_next = left_slot.valid;
                ent_next   = left_slot.ent;
            end
        end else if (cmd.rem) begin
            valid_next = right_slot.valid;
            ent_next   = right_slot.ent;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        ent_reg <= ent_next;
    end

    assign slot.valid = valid_reg;
    assign slot.ent   = ent_reg;

endmodule

@@ verif/sorted_priority_queue_tb.sv @@
// Testbench for sorted_priority_queue: random and directed insert/remove items.
module sorted_priority_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 600;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int HOLD_START   = 800;
    localparam int HOLD_CYCLES  = 200;

    typedef struct packed {
        logic [spq_pkg::OCC_W-1:0]          occupancy;
        logic signed [spq_pkg::PRIO_W-1:0]  removed_prio;
        logic signed [spq_pkg::VALUE_W-1:0] removed_value;
        logic                               removed_valid;
        spq_pkg::status_t                   status;
    } result_t;

    typedef struct packed {
        spq_pkg::op_t                       op;
        logic signed [spq_pkg::VALUE_W-1:0] value;
        logic signed [spq_pkg::PRIO_W-1:0]  prio;
        logic [3:0]                         gap;
    } queue_op_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;   // item_value[31:0], item_priority[47:32]
    logic [0:0]  s_axis_tuser  = '0;   // op[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;         // status[1:0], removed_valid[2], removed_value[34:3],
                                       // removed_priority[50:35], occupancy[55:51]

    sorted_priority_queue #(.CAPACITY(CAPACITY)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    queue_op_t       op_backlog[$];
    result_t         predicted_results[$];
    spq_pkg::entry_t held_entries[CAPACITY];
    int        held_count     = 0;
    int        ops_total      = 0;
    int        ops_accepted   = 0;
    int        results_seen   = 0;
    int        send_wait      = -1;
    int        take_wait      = 0;
    int        cycle_count    = 0;
    logic      rx_hold        = 1'b0;
    bit        failed         = 1'b0;
    queue_op_t next_op;
    result_t   got_result;
    result_t   want_result;

    initial begin
        forever #4 aclk = ~aclk;
    end

    // sorted insert behind equal priorities, remove from the front
    function automatic result_t predict_queue_op(
        spq_pkg::op_t                       op,
        logic signed [spq_pkg::VALUE_W-1:0] value,
        logic signed [spq_pkg::PRIO_W-1:0]  prio
    );
        result_t r;
        int      pos;
        r = '0;
        r.status = spq_pkg::ST_OK;
        if (op == spq_pkg::OP_INSERT) begin
            if (held_count >= CAPACITY) begin
                r.status = spq_pkg::ST_OVERFLOW;
            end else begin
                pos = 0;
                while (pos < held_count && held_entries[pos].prio <= prio)
                    pos++;
                for (int k = held_count; k > pos; k--)
                    held_entries[k] = held_entries[k-1];
                held_entries[pos].value = value;
                held_entries[pos].prio  = prio;
                held_count++;
            end
        end else if (held_count == 0) begin
            r.status = spq_pkg::ST_UNDERFLOW;
        end else begin
            r.removed_valid = 1'b1;
            r.removed_value = held_entries[0].value;
            r.removed_prio  = held_entries[0].prio;
            for (int k = 1; k < held_count; k++)
                held_entries[k-1] = held_entries[k];
            held_count--;
        end
        r.occupancy = held_count[spq_pkg::OCC_W-1:0];
        return r;
    endfunction

    task automatic add_op(spq_pkg::op_t op, logic [spq_pkg::VALUE_W-1:0] value,
                          logic [spq_pkg::PRIO_W-1:0] prio);
        queue_op_t q;
        q.op    = op;
        q.value = value;
        q.prio  = prio;
        q.gap   = ((ops_total % 64) < 16) ? 4'd0 : 4'($urandom_range(0, 12));
        op_backlog.push_back(q);
        ops_total++;
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
        if (seen !== want) begin
            $display("%0t %s mismatch: expected %h, got %h", $time, name, want, seen);
            failed = 1'b1;
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            send_wait = -1;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predicted_results.push_back(predict_queue_op(
                    spq_pkg::op_t'(s_axis_tuser[0]),
                    s_axis_tdata[31:0], s_axis_tdata[47:32]));
                ops_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (op_backlog.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else begin
                    if (send_wait < 0)
                        send_wait = op_backlog[0].gap;
                    if (send_wait == 0) begin
                        next_op = op_backlog.pop_front();
                        s_axis_tdata  <= {next_op.prio, next_op.value};
                        s_axis_tuser  <= next_op.op;
                        s_axis_tvalid <= 1'b1;
                        send_wait = -1;
                    end else begin
                        send_wait--;
                        s_axis_tvalid <= 1'b0;
                    end
                end
            end
        end
    end

    // long receiver stall so the output register fills and tready drops
    always @(posedge aclk) begin
        if (!aresetn) begin
            rx_hold <= 1'b0;
        end else begin
            rx_hold <= (cycle_count >= HOLD_START && cycle_count < HOLD_START + HOLD_CYCLES);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            take_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_result = result_t'(m_axis_tdata);
                if (predicted_results.size() == 0) begin
                    $display("%0t unexpected item: expected none, got %h", $time, m_axis_tdata);
                    failed = 1'b1;
                end else begin
                    want_result = predicted_results.pop_front();
                    check_field("status", want_result.status, got_result.status);
                    check_field("removed_valid", want_result.removed_valid,
                                got_result.removed_valid);
                    check_field("removed_value", want_result.removed_value,
                                got_result.removed_value);
                    check_field("removed_priority", 32'(want_result.removed_prio),
                                32'(got_result.removed_prio));
                    check_field("occupancy", want_result.occupancy, got_result.occupancy);
                end
                results_seen++;
                take_wait = ((results_seen % 50) < 15) ? 0 : $urandom_range(0, 12);
            end
            if (rx_hold || take_wait > 0) begin
                m_axis_tready <= 1'b0;
                if (!rx_hold)
                    take_wait--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int                         run_len;
        int                         mode;
        bit                         narrow;
        logic [spq_pkg::PRIO_W-1:0] p;
        spq_pkg::op_t               op;

        // underflow, field extremes, FIFO on equal priority, fill and overflow
        add_op(spq_pkg::OP_REMOVE, 32'h1234_5678, 16'h0001);
        add_op(spq_pkg::OP_INSERT, 32'h7FFF_FFFF, 16'h7FFF);
        add_op(spq_pkg::OP_INSERT, 32'h8000_0000, 16'h8000);
        add_op(spq_pkg::OP_INSERT, 32'h0000_0000, 16'h0000);
        add_op(spq_pkg::OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
        add_op(spq_pkg::OP_INSERT, 32'h0000_0001, 16'h0000);
        add_op(spq_pkg::OP_INSERT, 32'h0000_0002, 16'h0000);
        for (int i = 0; i < 10; i++)
            add_op(spq_pkg::OP_INSERT, 32'h100 + i, 16'h0005);
        add_op(spq_pkg::OP_INSERT, 32'hDEAD_BEEF, 16'h8000);
        for (int i = 0; i < 6; i++)
            add_op(spq_pkg::OP_REMOVE, $urandom, 16'($urandom));

        while (ops_total < 24 + RANDOM_ITEMS) begin
            mode    = $urandom_range(0, 9);
            run_len = $urandom_range(4, 24);
            narrow  = $urandom_range(0, 1);
            repeat (run_len) begin
                if (mode < 4)
                    op = ($urandom_range(0, 99) < 85) ? spq_pkg::OP_INSERT
                                                       : spq_pkg::OP_REMOVE;
                else if (mode < 7)
                    op = ($urandom_range(0, 99) < 85) ? spq_pkg::OP_REMOVE
                                                       : spq_pkg::OP_INSERT;
                else
                    op = spq_pkg::op_t'($urandom_range(0, 1));
                p = narrow ? 16'($urandom_range(0, 3)) - 16'd2 : 16'($urandom);
                add_op(op, $urandom, p);
            end
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (ops_accepted < ops_total)
            @(posedge aclk);
        while (predicted_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);

        if (failed) begin
            $display("tb: failure");
        end else begin
            $display("tb: success");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
verif/sorted_priority_queue_tb.sv
